FILE: rtl/core/pendulum_cascade_pid_defines.svh
// ----------------------------------------------------------------------------
// Pendulum cascade PID assertion macros
// Shared property forms for the port-level checker, clocked on aclk and
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PENDULUM_CASCADE_PID_DEFINES_SVH
`define PENDULUM_CASCADE_PID_DEFINES_SVH

// Same-cycle implication.
`define PCP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pcp_pkg.sv
// ----------------------------------------------------------------------------
// Pendulum cascade PID package
// Widths, loop constants, register map, opcodes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pcp_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 12;

    localparam int OP_W       = 2;
    localparam int SETPOINT_W = 12;
    localparam int GAIN_W     = 10;
    localparam int ENC_W      = 16;
    localparam int MAG_W      = 16;
    localparam int ERR_W      = 17;  // position error, angle integral
    localparam int DIFF_W     = 18;  // speed, angle error, angle delta
    localparam int MUL_A_W    = 18;
    localparam int PROD_W     = MUL_A_W + GAIN_W + 1;
    localparam int ACC_W      = 30;
    localparam int PA_W       = 9;   // clamped position angle term
    localparam int DIV_W      = 26;  // integral product magnitude
    localparam int RECIP_W    = 26;  // reciprocal of 100, scaled by 2^RECIP_SHIFT
    localparam int RECIP_SHIFT = 32;
    localparam int CNT_W      = 8;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int POS_SHIFT     = 5;
    localparam int POS_SCALE     = 1 << POS_SHIFT;
    localparam int POS_LIMIT     = 170;
    localparam int WINDOW        = 300;
    localparam int I_SCALE       = 100;
    localparam int I_PERIOD      = 200;
    localparam int TRAVERSE_SPAN = 1800;

    // ceil(2^32 / 100); exact quotient for every dividend below 2^30
    localparam logic [RECIP_W-1:0]    I_RECIP            = RECIP_W'(42949673);

    localparam logic [ENC_W-1:0]      TARGET_RESET       = ENC_W'(10000);
    localparam logic [SETPOINT_W-1:0] ANGLE_SP_RESET     = SETPOINT_W'(1080);
    localparam logic [GAIN_W-1:0]     ANGLE_P_RESET      = GAIN_W'(24);
    localparam logic [GAIN_W-1:0]     ANGLE_I_RESET      = GAIN_W'(53);
    localparam logic [GAIN_W-1:0]     ANGLE_D_RESET      = GAIN_W'(150);
    localparam logic [GAIN_W-1:0]     POS_P_RESET        = GAIN_W'(15);
    localparam logic [GAIN_W-1:0]     POS_D_RESET        = GAIN_W'(150);

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_HOME     = 2'd1,
        OP_TRAVERSE = 2'd2
    } op_t;

    typedef enum logic [PADDR_W-3:0] {
        REG_ANGLE_SETPOINT  = 3'd0,
        REG_ANGLE_P_GAIN    = 3'd1,
        REG_ANGLE_I_GAIN    = 3'd2,
        REG_ANGLE_D_GAIN    = 3'd3,
        REG_POSITION_P_GAIN = 3'd4,
        REG_POSITION_D_GAIN = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS_P,
        ST_POS_D,
        ST_ANGLE,
        ST_INT_MUL,
        ST_DIV,
        ST_DRV_P,
        ST_DRV_D,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/pendulum_cascade_pid.sv
// Sequencing: an in-window control tick steps ST_POS_P, ST_POS_D, ST_ANGLE, ST_INT_MUL,
//   ST_DIV, ST_DRV_P, ST_DRV_D and ST_DONE; one outside the window skips to ST_DONE.
//   A stalled result beat holds the sequencer; home and traverse give no beat.
// Occupancy: one tick at a time, bound by the shared multiplier and reciprocal divide by 100.
// Reset: synchronous active-low aresetn restores registers and loop state at once.
// ----------------------------------------------------------------------------
// Pendulum cascade PID controller
// Arm position PD feeds the angle setpoint of an angle PID; one multiplier
// is reused under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pendulum_cascade_pid
    import pcp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic      [PDATA_W-1:0]     prdata,
    output logic                        pready,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [OP_W-1:0]        s_operation,
    input  wire logic [SAMPLE_BITS-1:0] s_angle_sample,
    input  wire logic [ENC_W-1:0]       s_encoder_count,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [MAG_W-1:0]       m_drive_magnitude,
    output logic                        m_drive_reverse,
    output logic                        m_in_window
);

    localparam logic signed [DIFF_W-1:0] WIN_HI   = DIFF_W'(WINDOW);
    localparam logic signed [DIFF_W-1:0] WIN_LO   = -WIN_HI;
    localparam logic signed [ENC_W:0]    SPAN     = (ENC_W + 1)'(TRAVERSE_SPAN);
    localparam logic signed [ACC_W-1:0]  PA_HI    = ACC_W'(POS_LIMIT);
    localparam logic signed [ACC_W-1:0]  PA_LO    = -PA_HI;
    localparam logic signed [ACC_W-1:0]  RND_BIAS = ACC_W'(POS_SCALE - 1);

    // configuration
    logic [SETPOINT_W-1:0] angle_sp_reg;
    logic [GAIN_W-1:0]     angle_p_reg, angle_i_reg, angle_d_reg;
    logic [GAIN_W-1:0]     pos_p_reg, pos_d_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    // sequencer and loop state
    state_t                   state_reg, state_next;
    logic [SAMPLE_BITS-1:0]   prev_angle_reg, prev_angle_next;
    logic signed [ERR_W-1:0]  prev_err_reg, prev_err_next;
    logic signed [ERR_W-1:0]  integral_reg, integral_next;
    logic [CNT_W-1:0]         tick_cnt_reg, tick_cnt_next;
    logic [ENC_W-1:0]         target_reg, target_next;
    logic [ENC_W-1:0]         origin_reg, origin_next;
    logic                     traversing_reg, traversing_next;

    // working registers
    logic [SAMPLE_BITS-1:0]   angle_reg, angle_next;
    logic [ENC_W-1:0]         enc_reg, enc_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DIFF_W-1:0] ap_reg, ap_next;
    logic                     win_reg, win_next;
    logic [DIV_W-1:0]         div_reg, div_next;
    logic                     neg_reg, neg_next;

    // result register
    logic                     m_valid_reg, m_valid_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     rev_reg, rev_next;
    logic                     inwin_reg, inwin_next;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]  prod_raw;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   prod_mag;

    // datapath terms
    logic signed [ERR_W-1:0]  pos_err;
    logic signed [DIFF_W-1:0] speed;
    logic signed [DIFF_W-1:0] angle_ext, prev_angle_ext, setpoint_ext;
    logic signed [DIFF_W-1:0] werr, ang_diff, ap;
    logic                     win;
    logic signed [ACC_W-1:0]  acc_biased, pa_full;
    logic signed [PA_W-1:0]   tilt_offset;
    logic signed [ENC_W:0]    trav_dist;
    logic [DIV_W+RECIP_W-1:0] recip_prod;
    logic signed [ACC_W-1:0]  quot_signed;
    logic signed [ACC_W-1:0]  acc_mag;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_sp_reg <= ANGLE_SP_RESET;
            angle_p_reg  <= ANGLE_P_RESET;
            angle_i_reg  <= ANGLE_I_RESET;
            angle_d_reg  <= ANGLE_D_RESET;
            pos_p_reg    <= POS_P_RESET;
            pos_d_reg    <= POS_D_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ANGLE_SETPOINT:  angle_sp_reg <= pwdata[SETPOINT_W-1:0];
                REG_ANGLE_P_GAIN:    angle_p_reg  <= pwdata[GAIN_W-1:0];
                REG_ANGLE_I_GAIN:    angle_i_reg  <= pwdata[GAIN_W-1:0];
                REG_ANGLE_D_GAIN:    angle_d_reg  <= pwdata[GAIN_W-1:0];
                REG_POSITION_P_GAIN: pos_p_reg    <= pwdata[GAIN_W-1:0];
                REG_POSITION_D_GAIN: pos_d_reg    <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ANGLE_SETPOINT:  prdata = PDATA_W'(angle_sp_reg);
            REG_ANGLE_P_GAIN:    prdata = PDATA_W'(angle_p_reg);
            REG_ANGLE_I_GAIN:    prdata = PDATA_W'(angle_i_reg);
            REG_ANGLE_D_GAIN:    prdata = PDATA_W'(angle_d_reg);
            REG_POSITION_P_GAIN: prdata = PDATA_W'(pos_p_reg);
            REG_POSITION_D_GAIN: prdata = PDATA_W'(pos_d_reg);
            default:             prdata = '0;
        endcase
    end

    assign prod_raw = mul_a * $signed({1'b0, mul_b});
    assign prod     = ACC_W'(prod_raw);
    assign prod_mag = prod[ACC_W-1] ? -prod : prod;

    assign pos_err        = $signed({1'b0, enc_reg}) - $signed({1'b0, target_reg});
    assign speed          = DIFF_W'(pos_err) - DIFF_W'(prev_err_reg);
    assign angle_ext      = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, angle_reg});
    assign prev_angle_ext = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, prev_angle_reg});
    assign setpoint_ext   = $signed({{(DIFF_W-SETPOINT_W){1'b0}}, angle_sp_reg});
    assign werr           = setpoint_ext - angle_ext;
    assign ang_diff       = angle_ext - prev_angle_ext;
    assign win            = (werr < WIN_HI) && (werr > WIN_LO);

    // divide by 32 toward zero, then clamp
    assign acc_biased = acc_reg + (acc_reg[ACC_W-1] ? RND_BIAS : '0);
    assign pa_full    = acc_biased >>> POS_SHIFT;
    always_comb begin
        if (pa_full > PA_HI) begin
            tilt_offset = PA_W'(PA_HI);
        end else if (pa_full < PA_LO) begin
            tilt_offset = PA_W'(PA_LO);
        end else begin
            tilt_offset = PA_W'(pa_full);
        end
    end
    assign ap = setpoint_ext - DIFF_W'(tilt_offset) - angle_ext;

    assign trav_dist = $signed({1'b0, s_encoder_count}) - $signed({1'b0, origin_reg});

    // divide the integral product magnitude by 100 through its reciprocal
    assign recip_prod = div_reg * I_RECIP;

    assign quot_signed = neg_reg ? -$signed({{(ACC_W-DIV_W){1'b0}}, div_reg})
                                 :  $signed({{(ACC_W-DIV_W){1'b0}}, div_reg});
    assign acc_mag     = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    always_comb begin
        state_next      = state_reg;
        prev_angle_next = prev_angle_reg;
        prev_err_next   = prev_err_reg;
        integral_next   = integral_reg;
        tick_cnt_next   = tick_cnt_reg;
        target_next     = target_reg;
        origin_next     = origin_reg;
        traversing_next = traversing_reg;
        angle_next      = angle_reg;
        enc_next        = enc_reg;
        acc_next        = acc_reg;
        ap_next         = ap_reg;
        win_next        = win_reg;
        div_next        = div_reg;
        neg_next        = neg_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        mag_next        = mag_reg;
        rev_next        = rev_reg;
        inwin_next      = inwin_reg;
        mul_a           = '0;
        mul_b           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_operation)
                        OP_TICK: begin
                            angle_next = s_angle_sample;
                            enc_next   = s_encoder_count;
                            if (traversing_reg) begin
                                target_next = target_reg + ENC_W'(1);
                                if (trav_dist > SPAN) begin
                                    traversing_next = 1'b0;
                                end
                            end
                            state_next = ST_POS_P;
                        end
                        OP_HOME: begin
                            target_next = s_encoder_count;
                        end
                        OP_TRAVERSE: begin
                            target_next     = s_encoder_count;
                            origin_next     = s_encoder_count;
                            traversing_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_POS_P: begin
                mul_a      = MUL_A_W'(pos_err);
                mul_b      = pos_p_reg;
                acc_next   = prod;
                state_next = ST_POS_D;
            end
            ST_POS_D: begin
                mul_a         = MUL_A_W'(speed);
                mul_b         = pos_d_reg;
                acc_next      = acc_reg + prod;
                prev_err_next = pos_err;
                state_next    = ST_ANGLE;
            end
            ST_ANGLE: begin
                ap_next  = ap;
                win_next = win;
                if (win) begin
                    integral_next = ERR_W'(DIFF_W'(integral_reg) + werr);
                    state_next    = ST_INT_MUL;
                end else begin
                    state_next    = ST_DONE;
                end
            end
            ST_INT_MUL: begin
                mul_a      = MUL_A_W'(integral_reg);
                mul_b      = angle_i_reg;
                div_next   = prod_mag[DIV_W-1:0];
                neg_next   = prod[ACC_W-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                div_next   = DIV_W'(recip_prod[DIV_W+RECIP_W-1:RECIP_SHIFT]);
                state_next = ST_DRV_P;
            end
            ST_DRV_P: begin
                mul_a      = MUL_A_W'(ap_reg);
                mul_b      = angle_p_reg;
                acc_next   = quot_signed + prod;
                state_next = ST_DRV_D;
            end
            ST_DRV_D: begin
                mul_a      = MUL_A_W'(ang_diff);
                mul_b      = angle_d_reg;
                acc_next   = acc_reg - prod;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    inwin_next   = win_reg;
                    rev_next     = win_reg & acc_reg[ACC_W-1];
                    if (!win_reg) begin
                        mag_next = '0;
                    end else if (|acc_mag[ACC_W-1:MAG_W]) begin
                        mag_next = '1;
                    end else begin
                        mag_next = acc_mag[MAG_W-1:0];
                    end
                    prev_angle_next = angle_reg;
                    if (tick_cnt_reg >= CNT_W'(I_PERIOD - 1)) begin
                        tick_cnt_next = '0;
                        integral_next = '0;
                    end else begin
                        tick_cnt_next = tick_cnt_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_angle_reg <= '0;
            prev_err_reg   <= '0;
            integral_reg   <= '0;
            tick_cnt_reg   <= '0;
            target_reg     <= TARGET_RESET;
            origin_reg     <= '0;
            traversing_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_angle_reg <= prev_angle_next;
            prev_err_reg   <= prev_err_next;
            integral_reg   <= integral_next;
            tick_cnt_reg   <= tick_cnt_next;
            target_reg     <= target_next;
            origin_reg     <= origin_next;
            traversing_reg <= traversing_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        angle_reg <= angle_next;
        enc_reg   <= enc_next;
        acc_reg   <= acc_next;
        ap_reg    <= ap_next;
        win_reg   <= win_next;
        div_reg   <= div_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        rev_reg   <= rev_next;
        inwin_reg <= inwin_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_drive_magnitude = mag_reg;
    assign m_drive_reverse   = rev_reg;
    assign m_in_window       = inwin_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pcp_checker.sv
// ----------------------------------------------------------------------------
// Pendulum cascade PID port checker
// Watches the top-level ports for handshake, result and sequencing rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pendulum_cascade_pid_defines.svh"

module pcp_checker
    import pcp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic [OP_W-1:0]        s_operation,
    input wire logic [SAMPLE_BITS-1:0] s_angle_sample,
    input wire logic [ENC_W-1:0]       s_encoder_count,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [MAG_W-1:0]       m_drive_magnitude,
    input wire logic                   m_drive_reverse,
    input wire logic                   m_in_window
);

    logic [OP_W+SAMPLE_BITS+ENC_W-1:0] in_beat;
    logic [MAG_W+1:0]                  out_beat;
    logic                              tick_accept;
    logic                              zero_mag;

    assign in_beat     = {s_operation, s_angle_sample, s_encoder_count};
    assign out_beat    = {m_drive_magnitude, m_drive_reverse, m_in_window};
    assign tick_accept = s_valid && s_ready && (s_operation == OP_TICK);
    assign zero_mag    = (m_drive_magnitude == '0);

    // a stalled beat keeps its payload
    `PCP_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(out_beat), "beat changed")

    `PCP_ASSERT_NEXT(a_s_hold, s_valid && !s_ready, s_valid && $stable(in_beat), "input moved")

    // a control tick occupies the sequencer
    `PCP_ASSERT_NEXT(a_tick_busy, tick_accept, !s_ready, "ready after control tick")

    `PCP_ASSERT_IMPLY(a_rev_mag, m_valid && m_drive_reverse, !zero_mag, "reverse with zero drive")

    `PCP_ASSERT_IMPLY(a_out_zero, m_valid && !m_in_window, zero_mag && !m_drive_reverse, "drive off window")

endmodule

bind pendulum_cascade_pid pcp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pcp_checker (.*);

`default_nettype wire
